// File: design/xild_pkg.sv
`default_nettype none
package xild_pkg;

  // request kinds carried in s_tuser
  localparam logic [1:0] REQ_CODE = 2'd0;
  localparam logic [1:0] REQ_PRI  = 2'd1;
  localparam logic [1:0] REQ_EXT  = 2'd2;

  localparam int TABLE_DEPTH = 256;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam logic [5:0] MAX_INSN_LEN = 6'd15;
  localparam logic [5:0] LEN_SAT      = 6'd63;

  // flag table bit positions
  localparam int F_IMM8      = 0;
  localparam int F_IMM16     = 1;
  localparam int F_IMM1632   = 2;
  localparam int F_IMM163264 = 3;
  localparam int F_EXT       = 4;
  localparam int F_REL       = 5;
  localparam int F_MODRM     = 6;
  localparam int F_PFX       = 7;

  // status bit positions
  localparam int S_PFX   = 0;
  localparam int S_REX   = 1;
  localparam int S_MODRM = 2;
  localparam int S_SIB   = 3;
  localparam int S_DISP  = 4;
  localparam int S_IMM   = 5;
  localparam int S_REL   = 6;
  localparam int S_INV   = 7;

  // decode phases
  localparam logic [2:0] PH_PREFIX = 3'd0;
  localparam logic [2:0] PH_REX    = 3'd1;
  localparam logic [2:0] PH_OP2    = 3'd2;
  localparam logic [2:0] PH_OP3    = 3'd3;
  localparam logic [2:0] PH_MODRM  = 3'd4;
  localparam logic [2:0] PH_SIB    = 3'd5;
  localparam logic [2:0] PH_SKIP   = 3'd6;

  typedef struct packed {
    logic [2:0] phase;
    logic [5:0] byte_count;
    logic       osz;
    logic       asz;
    logic       rex_w;
    logic [7:0] flags;
    logic [7:0] opcode;
    logic [3:0] skip;
    logic [7:0] status;
    logic [7:0] rex;
    logic [7:0] modrm;
    logic [7:0] sib;
    logic [4:0] op_off;
    logic [1:0] op_size;
    logic [4:0] disp_off;
    logic [2:0] disp_len;
    logic [4:0] imm_off;
    logic [3:0] imm_len;
    logic       one_byte;
  } xild_state_t;

  localparam xild_state_t STATE_START = '0;

  typedef struct packed {
    logic [3:0] imm_len;
    logic [4:0] imm_off;
    logic [2:0] disp_len;
    logic [4:0] disp_off;
    logic [1:0] op_size;
    logic [4:0] op_off;
    logic [7:0] sib;
    logic [7:0] modrm;
    logic [7:0] rex;
    logic [7:0] status;
    logic [5:0] length;
  } xild_result_t;

endpackage
`default_nettype wire

// File: design/x86_instruction_length_decoder.sv
`default_nettype none
// x86 instruction length decoder, one code byte or table write per item
// the last byte of an instruction reaches m_tdata through the input stage and
// result registers; throughput one item per cycle unless m_tready stalls it, set
// by the single registered read of the flag tables and one decode step per byte
// reset (rst, synchronous) clears the pipeline, the decode state and mode_64;
// the flag tables are not cleared and must be written before they are used
module x86_instruction_length_decoder import xild_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // mode_64 register
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // code_byte, table_index, table_entry
  input  wire logic [1:0]  s_tuser,   // req_type
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata    // insn_length, status_bits, rex_value,
                                      // modrm_value, sib_value, opcode_offset,
                                      // opcode_size, disp_off, disp_len,
                                      // imm_off, imm_len, zero pad
);

  logic mode_64;

  // flag tables, one read port each, read at the code byte
  logic [7:0] pflag_mem [TABLE_DEPTH];
  logic [7:0] eflag_mem [TABLE_DEPTH];
  logic [7:0] pflag_rd;
  logic [7:0] eflag_rd;

  // input stage
  logic       s1_valid;
  logic [1:0] s1_type;
  logic [7:0] s1_byte;

  xild_state_t  dec_state;
  xild_state_t  state_next;
  logic         step_emit;
  xild_result_t step_result;

  logic s_acc;
  logic advance;
  logic do_step;

  logic [TABLE_AW-1:0] wr_idx;
  logic [TABLE_AW-1:0] rd_idx;
  logic [7:0]          wr_entry;

  assign wr_idx   = s_tdata[15:8];
  assign wr_entry = s_tdata[23:16];
  assign rd_idx   = s_tdata[7:0];

  // the result register frees up whenever it is empty or being taken
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign s_acc    = s_tvalid && s_tready;
  assign do_step  = s1_valid && advance && (s1_type == REQ_CODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_64 <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_64 <= cfg_wr_data;
    end
  end

  // table writes land at accept so a following byte already sees them
  always_ff @(posedge clk) begin
    if (s_acc && s_tuser == REQ_PRI) begin
      pflag_mem[wr_idx] <= wr_entry;
    end
    if (s_acc && s_tuser == REQ_EXT) begin
      eflag_mem[wr_idx] <= wr_entry;
    end
    if (s_acc) begin
      pflag_rd <= pflag_mem[rd_idx];
      eflag_rd <= eflag_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_type <= s_tuser;
      s1_byte <= s_tdata[7:0];
    end
  end

  xild_step u_step (
    .mode_64    (mode_64),
    .cur        (dec_state),
    .code_byte  (s1_byte),
    .pflags     (pflag_rd),
    .eflags     (eflag_rd),
    .state_next (state_next),
    .emit       (step_emit),
    .result     (step_result)
  );

  // decode state moves only on code bytes; table writes leave it alone
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_state <= STATE_START;
    end else if (do_step) begin
      dec_state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= do_step && step_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step && step_emit) begin
      m_tdata <= {2'b00,
                  step_result.imm_len,
                  step_result.imm_off,
                  step_result.disp_len,
                  step_result.disp_off,
                  step_result.op_size,
                  step_result.op_off,
                  step_result.sib,
                  step_result.modrm,
                  step_result.rex,
                  step_result.status,
                  step_result.length};
    end
  end

endmodule
`default_nettype wire

// File: design/xild_step.sv
`default_nettype none
module xild_step import xild_pkg::*; (
  input  wire logic         mode_64,
  input  wire xild_state_t  cur,
  input  wire logic [7:0]   code_byte,
  input  wire logic [7:0]   pflags,
  input  wire logic [7:0]   eflags,
  output xild_state_t       state_next,
  output logic              emit,
  output xild_result_t      result
);

  function automatic logic [5:0] sat_inc(input logic [5:0] v);
    sat_inc = (v == LEN_SAT) ? LEN_SAT : v + 6'd1;
  endfunction

  xild_state_t st;
  logic        inv;
  logic        take;
  logic        aft;
  logic        md;
  logic        fin;
  logic [3:0]  imm;
  logic [1:0]  mdmod;
  logic [2:0]  mdrm;

  always_comb begin
    st    = cur;
    emit  = 1'b0;
    inv   = 1'b0;
    take  = 1'b0;
    aft   = 1'b0;
    md    = 1'b0;
    fin   = 1'b0;
    imm   = 4'd0;
    mdmod = 2'd0;
    mdrm  = 3'd0;

    case (cur.phase)
      PH_PREFIX: begin
        if (pflags[F_PFX]) begin
          if (code_byte == 8'h66) st.osz = 1'b1;
          if (code_byte == 8'h67) st.asz = 1'b1;
          st.byte_count    = sat_inc(st.byte_count);
          st.status[S_PFX] = 1'b1;
          if (st.byte_count >= MAX_INSN_LEN) begin
            emit = 1'b1;
            inv  = 1'b1;
          end
        end else if (mode_64 && code_byte[7:4] == 4'h4) begin
          st.rex           = code_byte;
          st.rex_w         = code_byte[3];
          st.status[S_REX] = 1'b1;
          st.byte_count    = sat_inc(st.byte_count);
          st.phase         = PH_REX;
        end else begin
          take = 1'b1;
        end
      end
      PH_REX: begin
        if (code_byte[7:4] == 4'h4) begin
          // second rex ends the instruction as invalid
          st.byte_count = sat_inc(st.byte_count);
          emit = 1'b1;
          inv  = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      PH_OP2: begin
        st.byte_count = sat_inc(st.byte_count);
        st.op_size    = 2'd2;
        st.opcode     = code_byte;
        st.flags      = eflags;
        if (eflags[F_PFX]) begin
          emit = 1'b1;
          inv  = 1'b1;
        end else if (eflags[F_EXT]) begin
          st.phase = PH_OP3;
        end else begin
          aft = 1'b1;
        end
      end
      PH_OP3: begin
        st.byte_count = sat_inc(st.byte_count);
        st.op_size    = 2'd3;
        st.opcode     = code_byte;
        aft = 1'b1;
      end
      PH_MODRM: begin
        st.modrm           = code_byte;
        st.status[S_MODRM] = 1'b1;
        st.byte_count      = sat_inc(st.byte_count);
        // group 3 test forms carry an immediate
        if (st.one_byte && code_byte[5:3] <= 3'd1) begin
          if (st.opcode == 8'hF6) st.flags[F_IMM8]      = 1'b1;
          if (st.opcode == 8'hF7) st.flags[F_IMM163264] = 1'b1;
        end
        if (code_byte[7:6] != 2'd3 && code_byte[2:0] == 3'd4 && (mode_64 || !st.asz)) begin
          st.phase = PH_SIB;
        end else begin
          md = 1'b1;
        end
      end
      PH_SIB: begin
        st.sib           = code_byte;
        st.status[S_SIB] = 1'b1;
        st.byte_count    = sat_inc(st.byte_count);
        if (code_byte[2:0] == 3'd5 && st.modrm[7:6] == 2'd0) st.disp_len = 3'd4;
        md = 1'b1;
      end
      default: begin
        st.byte_count = sat_inc(st.byte_count);
        if (st.skip != 4'd0) st.skip = st.skip - 4'd1;
        if (st.skip == 4'd0) emit = 1'b1;
      end
    endcase

    if (take) begin
      st.op_off     = st.byte_count[4:0];
      st.op_size    = 2'd1;
      st.byte_count = sat_inc(st.byte_count);
      if (code_byte == 8'h0F) begin
        st.phase = PH_OP2;
      end else begin
        st.opcode   = code_byte;
        st.one_byte = 1'b1;
        st.flags    = pflags;
        // moffs forms take their size from the address-size prefix
        if (code_byte inside {[8'hA0:8'hA3]}) st.osz = st.asz;
        aft = 1'b1;
      end
    end

    if (aft) begin
      if (st.flags[F_MODRM]) st.phase = PH_MODRM;
      else fin = 1'b1;
    end

    // displacement size from mod and r/m
    if (md) begin
      mdmod = st.modrm[7:6];
      mdrm  = st.modrm[2:0];
      case (mdmod)
        2'd0: begin
          if (mode_64) begin
            if (mdrm == 3'd5) begin
              st.disp_len      = 3'd4;
              st.status[S_REL] = 1'b1;
            end
          end else if (st.asz) begin
            if (mdrm == 3'd6) st.disp_len = 3'd2;
          end else if (mdrm == 3'd5) begin
            st.disp_len = 3'd4;
          end
        end
        2'd1:    st.disp_len = 3'd1;
        2'd2:    st.disp_len = (!mode_64 && st.asz) ? 3'd2 : 3'd4;
        default: st.disp_len = st.disp_len;
      endcase
      fin = 1'b1;
    end

    if (fin) begin
      if (st.disp_len != 3'd0) begin
        st.disp_off       = st.byte_count[4:0];
        st.status[S_DISP] = 1'b1;
      end
      if (st.one_byte && mode_64 && st.rex_w && st.opcode inside {[8'hB8:8'hBF]} &&
          st.flags[F_IMM163264]) begin
        imm = 4'd8;
      end else if (st.flags[F_IMM1632] || st.flags[F_IMM163264]) begin
        imm = st.osz ? 4'd2 : 4'd4;
      end
      imm = imm + {2'b00, st.flags[F_IMM16:F_IMM8]};
      if (imm != 4'd0) begin
        st.imm_len       = imm;
        st.imm_off       = st.byte_count[4:0] + {2'b00, st.disp_len};
        st.status[S_IMM] = 1'b1;
        if (st.flags[F_REL]) st.status[S_REL] = 1'b1;
      end
      st.skip = {1'b0, st.disp_len} + imm;
      if (st.skip == 4'd0) emit = 1'b1;
      else st.phase = PH_SKIP;
    end

    result.length    = st.byte_count;
    result.status    = st.status;
    result.status[S_INV] = st.status[S_INV] | inv | (st.byte_count > MAX_INSN_LEN);
    result.rex       = st.rex;
    result.modrm     = st.modrm;
    result.sib       = st.sib;
    result.op_off    = st.op_off;
    result.op_size   = st.op_size;
    result.disp_off  = st.disp_off;
    result.disp_len  = st.disp_len;
    result.imm_off   = st.imm_off;
    result.imm_len   = st.imm_len;

    state_next = emit ? STATE_START : st;
  end

endmodule
`default_nettype wire
